// ----- sv/arpc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the roll posture classifier.
// Used by the CORDIC stage module, the top level, the checker and the testbench; depends on nothing else.
package arpc_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STEPS    = 16;
  localparam int ACC_FRAC        = 24;
  localparam int TABLE_LEN       = 24;
  localparam int PRESCALE_SHIFT  = 20;
  localparam int NUM_STEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  localparam int SAMPLE_W = 16;
  localparam int ANGLE_W  = 17;
  localparam int CLASS_W  = 2;
  localparam int STEP_W   = 5;
  localparam int REG_IDX_W = 2;

  // Vector datapath: 16-bit counts scaled by 2^20, CORDIC gain and sqrt(2) growth.
  localparam int VEC_W = SAMPLE_W + PRESCALE_SHIFT + 4;
  // Angle accumulator in degrees with ACC_FRAC fraction bits, up to about 280 degrees.
  localparam int ACC_W = ACC_FRAC + 10;

  localparam int ROUND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int ROLL_W   = ACC_W + 1 - ROUND_SH;

  localparam logic signed [ACC_W-1:0] HALF_TURN    = ACC_W'(64'd180 << ACC_FRAC);
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(64'd90 << ACC_FRAC);
  localparam logic signed [ROLL_W-1:0] ROLL_LIMIT  = ROLL_W'(64'd180 << ANGLE_FRAC_BITS);

  localparam logic [ANGLE_W-1:0] LOW_THR_RESET  = ANGLE_W'(-23040);
  localparam logic [ANGLE_W-1:0] HIGH_THR_RESET = ANGLE_W'(-20480);

  localparam logic [REG_IDX_W-1:0] REG_LOW_THR  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THR = REG_IDX_W'(1);

  typedef enum logic [CLASS_W-1:0] {
    CLASS_LOW  = 2'd0,
    CLASS_MID  = 2'd1,
    CLASS_HIGH = 2'd2
  } arpc_class_e;

  // atan(2^-i) in degrees with 24 fraction bits.
  localparam logic [31:0] ATAN_Q24 [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  typedef struct packed {
    logic                    bypass;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
  } arpc_vec_t;

  function automatic logic signed [ACC_W-1:0] atan_lookup(input logic [STEP_W-1:0] step);
    logic signed [ACC_W-1:0] val;
    val = '0;
    if (int'(step) < TABLE_LEN) begin
      val = ACC_W'(ATAN_Q24[step]);
    end
    return val;
  endfunction

endpackage

// ----- sv/arpc_cordic_stage.sv -----
`timescale 1ns / 1ps
// One vectoring CORDIC iteration with its own pipeline register and valid bit.
// Depends on arpc_pkg for the vector type and the arctangent table.
module arpc_cordic_stage import arpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [STEP_W-1:0] step_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  arpc_vec_t         in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output arpc_vec_t         out_data_o
);

  logic      valid_q, valid_d;
  arpc_vec_t data_q, data_d;
  logic signed [VEC_W-1:0] x_sh, y_sh;
  logic signed [ACC_W-1:0] angle;

  assign in_ready_o = !valid_q || out_ready_i;
  assign x_sh  = in_data_i.x >>> step_i;
  assign y_sh  = in_data_i.y >>> step_i;
  assign angle = atan_lookup(step_i);

  always_comb begin
    data_d = in_data_i;
    if (!in_data_i.bypass) begin
      // Rotate toward the positive x axis; the sign of y picks the direction.
      if (in_data_i.y > 0) begin
        data_d.x   = in_data_i.x + y_sh;
        data_d.y   = in_data_i.y - x_sh;
        data_d.acc = in_data_i.acc + angle;
      end else begin
        data_d.x   = in_data_i.x - y_sh;
        data_d.y   = in_data_i.y + x_sh;
        data_d.acc = in_data_i.acc - angle;
      end
    end
  end

  assign valid_d = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- sv/accel_roll_posture_classifier.sv -----
`timescale 1ns / 1ps
// Top level of the roll posture classifier: input setup, CORDIC pipeline, rounding and class.
// Depends on arpc_pkg and arpc_cordic_stage.

// Each item is one Y/Z accelerometer sample; the block returns the roll angle atan2(y, z)
// in degrees with 8 fraction bits, range (-180, 180], and a posture class from the two
// threshold registers. It takes one item every clock cycle while the output side is not
// stalled. Each result passes through one setup stage, one register stage per CORDIC
// iteration and one stage for rounding, clamping and the threshold compares. Every
// stage has its own valid bit and moves whenever the stage after it is empty or moving,
// so empty slots absorb stalls on the output side.
// Thresholds should only be written while no item is in flight.
module accel_roll_posture_classifier import arpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [ANGLE_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  accel_y_i,
  input  logic [SAMPLE_W-1:0]  accel_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ANGLE_W-1:0]   roll_angle_o,
  output logic [CLASS_W-1:0]   posture_class_o
);

  // Threshold registers.
  logic [ANGLE_W-1:0] low_thr_q, high_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RESET;
      high_thr_q <= HIGH_THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LOW_THR:  low_thr_q  <= cfg_data_i;
        REG_HIGH_THR: high_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Setup stage: special axes, scaling and folding the left half plane onto the right.
  logic signed [SAMPLE_W-1:0] y_s, z_s;
  logic signed [VEC_W-1:0]    y_ext, z_ext;
  arpc_vec_t                  setup_d, setup_q;
  logic                       setup_valid_q;
  logic                       setup_ready;

  assign y_s   = $signed(accel_y_i);
  assign z_s   = $signed(accel_z_i);
  assign y_ext = {{(VEC_W-SAMPLE_W-PRESCALE_SHIFT){y_s[SAMPLE_W-1]}}, y_s,
                  {PRESCALE_SHIFT{1'b0}}};
  assign z_ext = {{(VEC_W-SAMPLE_W-PRESCALE_SHIFT){z_s[SAMPLE_W-1]}}, z_s,
                  {PRESCALE_SHIFT{1'b0}}};

  always_comb begin
    setup_d.bypass = 1'b0;
    setup_d.x      = z_ext;
    setup_d.y      = y_ext;
    setup_d.acc    = '0;
    if (y_s == 0) begin
      setup_d.bypass = 1'b1;
      setup_d.acc    = (z_s < 0) ? HALF_TURN : '0;
    end else if (z_s == 0) begin
      setup_d.bypass = 1'b1;
      setup_d.acc    = (y_s > 0) ? QUARTER_TURN : -QUARTER_TURN;
    end else if (z_s < 0) begin
      setup_d.x   = -z_ext;
      setup_d.y   = -y_ext;
      setup_d.acc = (y_s > 0) ? HALF_TURN : -HALF_TURN;
    end
  end

  logic      stage_valid [NUM_STEPS+1];
  logic      stage_ready [NUM_STEPS+1];
  arpc_vec_t stage_data  [NUM_STEPS+1];

  assign setup_ready     = !setup_valid_q || stage_ready[0];
  assign in_ready_o      = setup_ready;
  assign stage_valid[0]  = setup_valid_q;
  assign stage_data[0]   = setup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_valid_q <= 1'b0;
    end else if (setup_ready) begin
      setup_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (setup_ready && in_valid_i) begin
      setup_q <= setup_d;
    end
  end

  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    arpc_cordic_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (STEP_W'(i)),
      .in_valid_i  (stage_valid[i]),
      .in_ready_o  (stage_ready[i]),
      .in_data_i   (stage_data[i]),
      .out_valid_o (stage_valid[i+1]),
      .out_ready_i (stage_ready[i+1]),
      .out_data_o  (stage_data[i+1])
    );
  end

  // Output stage: round half up, clamp to (-180, 180], classify.
  logic                      out_valid_q;
  logic [ANGLE_W-1:0]        roll_q, roll_d;
  arpc_class_e               class_q, class_d;
  logic signed [ACC_W:0]     acc_rnd;
  logic signed [ROLL_W-1:0]  roll_full, roll_clamp, low_ext, high_ext;
  logic signed [ACC_W-1:0]   acc_last;

  assign stage_ready[NUM_STEPS] = !out_valid_q || out_ready_i;
  assign acc_last  = stage_data[NUM_STEPS].acc;
  assign acc_rnd   = {acc_last[ACC_W-1], acc_last} + (ACC_W+1)'(64'd1 << (ROUND_SH-1));
  assign roll_full = ROLL_W'(acc_rnd >>> ROUND_SH);
  assign low_ext   = {{(ROLL_W-ANGLE_W){low_thr_q[ANGLE_W-1]}}, low_thr_q};
  assign high_ext  = {{(ROLL_W-ANGLE_W){high_thr_q[ANGLE_W-1]}}, high_thr_q};

  always_comb begin
    roll_clamp = roll_full;
    // A result at or below minus 180 degrees is reported as plus 180.
    if (roll_full > ROLL_LIMIT || roll_full <= -ROLL_LIMIT) begin
      roll_clamp = ROLL_LIMIT;
    end
    roll_d = roll_clamp[ANGLE_W-1:0];
    if (roll_clamp < low_ext) begin
      class_d = CLASS_LOW;
    end else if (roll_clamp < high_ext) begin
      class_d = CLASS_MID;
    end else begin
      class_d = CLASS_HIGH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_ready[NUM_STEPS]) begin
      out_valid_q <= stage_valid[NUM_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[NUM_STEPS] && stage_valid[NUM_STEPS]) begin
      roll_q  <= roll_d;
      class_q <= class_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign roll_angle_o    = roll_q;
  assign posture_class_o = class_q;

  // An empty output register means every stage can move, so an item is taken.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input not ready while the output register is empty");

  a_roll_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(roll_angle_o) <= $signed(ROLL_LIMIT[ANGLE_W-1:0]) &&
                     $signed(roll_angle_o) > -$signed(ROLL_LIMIT[ANGLE_W-1:0])))
    else $error("roll angle outside (-180, 180]");

  a_class_matches_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((posture_class_o == CLASS_LOW) == ($signed(roll_angle_o) < $signed(low_thr_q))) &&
      ((posture_class_o == CLASS_MID) == (!($signed(roll_angle_o) < $signed(low_thr_q)) &&
                                          ($signed(roll_angle_o) < $signed(high_thr_q)))))
    else $error("posture class disagrees with roll angle and thresholds");

endmodule

// ----- sim/arpc_roll_checker.sv -----
`timescale 1ns / 1ps
// Checker for the roll posture classifier: watches the register, sample and result channels,
// predicts roll and class for every accepted sample and compares each accepted result.
// Depends on arpc_pkg for widths, register indexes and the class encoding.
module arpc_roll_checker import arpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [ANGLE_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [SAMPLE_W-1:0]  accel_y_i,
  input  logic [SAMPLE_W-1:0]  accel_z_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [ANGLE_W-1:0]   roll_angle_i,
  input  logic [CLASS_W-1:0]   posture_class_i,
  output int                   mismatch_count_o,
  output int                   pending_count_o
);

  // atan(2^-i) in degrees with 24 fraction bits.
  localparam longint TILT_ATAN_Q24 [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };
  localparam int TILT_STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  typedef struct {
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic signed [ANGLE_W-1:0]  roll;
    arpc_class_e                cls;
  } tilt_expect_t;

  tilt_expect_t              roll_queue[$];
  logic signed [ANGLE_W-1:0] low_thr;
  logic signed [ANGLE_W-1:0] high_thr;
  int                        mismatches;
  int                        result_idx;

  // Vectoring CORDIC on the prescaled counts; angle in degrees with 24 fraction bits.
  function automatic longint cordic_roll_q24(input longint y, input longint z);
    longint half;
    longint x;
    longint v;
    longint acc;
    longint t;
    half = longint'(180) <<< 24;
    if (y == 0) return (z < 0) ? half : 0;
    if (z == 0) return (y > 0) ? half / 2 : -(half / 2);
    acc = 0;
    x = z <<< 20;
    v = y <<< 20;
    // Left half plane: rotate by a half turn first so the iterations converge.
    if (z < 0) begin
      x = -x;
      v = -v;
      acc = (y > 0) ? half : -half;
    end
    for (int i = 0; i < TILT_STEPS; i++) begin
      t = x;
      if (v > 0) begin
        x = x + (v >>> i);
        v = v - (t >>> i);
        acc += TILT_ATAN_Q24[i];
      end else begin
        x = x - (v >>> i);
        v = v + (t >>> i);
        acc -= TILT_ATAN_Q24[i];
      end
    end
    return acc;
  endfunction

  function automatic tilt_expect_t predict_posture(input logic signed [SAMPLE_W-1:0] y,
                                                   input logic signed [SAMPLE_W-1:0] z);
    tilt_expect_t e;
    longint       lim;
    longint       roll;
    int           sh;
    sh = 24 - ANGLE_FRAC_BITS;
    lim = longint'(180) <<< ANGLE_FRAC_BITS;
    roll = (cordic_roll_q24(longint'(y), longint'(z)) + (longint'(1) <<< (sh - 1))) >>> sh;
    if (roll > lim) roll = lim;
    // Anything that rounds to minus a half turn is reported as plus a half turn.
    if (roll <= -lim) roll = lim;
    e.y = y;
    e.z = z;
    e.roll = ANGLE_W'(roll);
    if (roll < longint'(low_thr)) e.cls = CLASS_LOW;
    else if (roll < longint'(high_thr)) e.cls = CLASS_MID;
    else e.cls = CLASS_HIGH;
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tilt_expect_t e;
    if (!rst_ni) begin
      low_thr = LOW_THR_RESET;
      high_thr = HIGH_THR_RESET;
      roll_queue.delete();
      mismatches = 0;
      result_idx = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_LOW_THR) low_thr = cfg_data_i;
        else if (cfg_index_i == REG_HIGH_THR) high_thr = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (roll_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d: roll %0d class %0d", result_idx,
                     $signed(roll_angle_i), posture_class_i);
        end else begin
          e = roll_queue.pop_front();
          if (roll_angle_i !== e.roll || posture_class_i !== e.cls) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d (y %0d z %0d): roll exp %0d got %0d, class exp %0d got %0d",
                       result_idx, e.y, e.z, e.roll, $signed(roll_angle_i), e.cls,
                       posture_class_i);
          end
        end
        result_idx++;
      end
      if (in_valid_i && in_ready_i) roll_queue.push_back(predict_posture(accel_y_i, accel_z_i));
    end
    mismatch_count_o <= mismatches;
    pending_count_o <= roll_queue.size();
  end

endmodule

// ----- sim/tb_accel_roll_posture_classifier.sv -----
`timescale 1ns / 1ps
// Testbench top for the roll posture classifier: clock, reset, register writes, sample and
// result traffic, and the verdict. Depends on arpc_pkg, the block and arpc_roll_checker.
module tb_accel_roll_posture_classifier import arpc_pkg::*;;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 117;
  localparam int NUM_PHASES  = 6;
  localparam int DRAIN_WAIT  = 3 * (NUM_STEPS + 2);

  // Indexes with no register behind them; writes there must leave the thresholds alone.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = REG_IDX_W'(3);

  localparam logic signed [SAMPLE_W-1:0] DIR_Y [22] = '{
    0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768,
    -32768, 32767, -1, 1, -32768, 1, -1, 1, -1, -32768, 12345
  };
  localparam logic signed [SAMPLE_W-1:0] DIR_Z [22] = '{
    0, 1, -1, 32767, -32768, 0, 0, 0, 0, 32767, -32768,
    32767, -32768, -32768, -32768, -1, 1, 1, -1, -1, 1, -23456
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [ANGLE_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  accel_y;
  logic [SAMPLE_W-1:0]  accel_z;
  logic                 out_valid;
  logic                 out_ready;
  logic [ANGLE_W-1:0]   roll_angle;
  logic [CLASS_W-1:0]   posture_class;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  int backpressure_cycles = 0;
  int samples_sent = 0;
  int settings_used = 1;
  int send_gap = 0;
  int hold_off = 0;
  int hold_off_total = 0;
  bit quiet = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  accel_roll_posture_classifier u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .accel_y_i       (accel_y),
    .accel_z_i       (accel_z),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .roll_angle_o    (roll_angle),
    .posture_class_o (posture_class)
  );

  arpc_roll_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .accel_y_i        (accel_y),
    .accel_z_i        (accel_z),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .roll_angle_i     (roll_angle),
    .posture_class_i  (posture_class),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && !in_ready) backpressure_cycles <= backpressure_cycles + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [ANGLE_W-1:0] random_threshold();
    return ANGLE_W'($urandom_range(0, 92160) - 46080);
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int lo, input int hi);
    write_reg(REG_LOW_THR, ANGLE_W'(lo));
    write_reg(REG_HIGH_THR, ANGLE_W'(hi));
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, ANGLE_W'($urandom));
    settings_used++;
  endtask

  // Valid stays up across back-to-back items; it only drops when a gap follows.
  task automatic send_sample(input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] z);
    if (send_gap > 0) begin
      in_valid <= 1'b0;
      repeat (send_gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_y <= y;
    accel_z <= z;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    send_gap = pick_gap();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    send_gap = 0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Half arbitrary samples; the rest aimed at tiny values, the axes, the region just short of
  // a half turn where the sign of the result flips, the extremes and scaled-down samples.
  task automatic random_sample(output logic signed [SAMPLE_W-1:0] y,
                               output logic signed [SAMPLE_W-1:0] z);
    logic signed [SAMPLE_W-1:0] picks [5];
    int kind;
    picks = '{-32768, 32767, -1, 0, 1};
    kind = $urandom_range(0, 9);
    y = SAMPLE_W'($urandom);
    z = SAMPLE_W'($urandom);
    case (kind)
      5: begin
        y = SAMPLE_W'($urandom_range(0, 8) - 4);
        z = SAMPLE_W'($urandom_range(0, 8) - 4);
      end
      6: begin
        if ($urandom_range(0, 1) != 0) y = '0;
        else z = '0;
      end
      7: begin
        z = SAMPLE_W'(-$urandom_range(16384, 32768));
        y = SAMPLE_W'($urandom_range(0, 64) - 32);
      end
      8: begin
        y = picks[$urandom_range(0, 4)];
        z = picks[$urandom_range(0, 4)];
      end
      9: begin
        y = $signed(y) >>> $urandom_range(0, 14);
        z = $signed(z) >>> $urandom_range(0, 14);
      end
      default: ;
    endcase
  endtask

  // Result side: a random wait per item, and one long hold-off when requested.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off_total += hold_off;
        hold_off = 0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    int failures;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LOW_THR;
    cfg_data = '0;
    in_valid = 1'b0;
    accel_y = '0;
    accel_z = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples under the reset thresholds.
    foreach (DIR_Y[i]) send_sample(DIR_Y[i], DIR_Z[i]);
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: set_thresholds(-46080, 46080);
        1: set_thresholds(46080, -46080);
        2: set_thresholds(0, 0);
        3: set_thresholds(-46080, -46080);
        4: set_thresholds(46080, 46080);
        default: set_thresholds($signed(random_threshold()), $signed(random_threshold()));
      endcase
      quiet = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the result side off long enough to fill the pipe and stall the input.
        if (phase == 1 && n == 30) hold_off = 300;
        random_sample(y, z);
        send_sample(y, z);
      end
      wait_drained();
    end
    quiet = 1'b0;

    repeat (DRAIN_WAIT) @(posedge clk);
    failures = mismatch_count + pending_count;
    if (pending_count != 0) $display("%0d expected results never arrived", pending_count);
    $display("Sent %0d samples under %0d threshold settings: axes, extremes, near half turn.",
             samples_sent, settings_used);
    $display("Result side held off %0d cycles in one stretch; input stalled on %0d cycles.",
             hold_off_total, backpressure_cycles);
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
